FILE: rtl/lcdm_pkg.sv
`timescale 1ns / 1ps

package lcdm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_EN0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_EN1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ADDR0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ADDR1   = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] SET_DDRAM_OP = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMD  = 3'b010,
    S_DATA = 3'b100
  } state_t;

endpackage

FILE: rtl/char_lcd_marquee_scroller.sv
`timescale 1ns / 1ps

// Channel | Direction | tdata        | tuser                      | tlast
// in_     | slave     | char_code    | [0] command, [1] line_sel  | char_last
// out_    | master    | byte_value   | [0] is_command             | last_of_run
// cfg_    | write     | cfg_data     | cfg_index selects register | -
//
// A load transaction leaves the block idle, so it is ready again next cycle.
// A quiet tick keeps it idle; else each redrawn line sends a command and LINE_CHARS
// bytes, one byte per cycle unless stalled, from the shared index unit and text RAM.
// Output stalls hold the sequencer; a finished byte waits in the output register.
// Reset clears lengths, scroll positions, pending flags and the tick counter.

module char_lcd_marquee_scroller #(
  parameter int LINE_CHARS = 16,
  parameter int MAX_TEXT   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // char_code
  input  logic [1:0]                     in_tuser,   // command, line_select
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // byte_value
  output logic                           out_tuser,  // is_command
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [lcdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lcdm_pkg::*;

  localparam int LW    = $clog2(MAX_TEXT + 1);
  localparam int IMAX  = (LINE_CHARS > MAX_TEXT + 1) ? LINE_CHARS : MAX_TEXT + 1;
  localparam int IW    = $clog2(IMAX);
  localparam int AW    = $clog2(2 * MAX_TEXT);
  localparam int CW    = $clog2(LINE_CHARS);

  logic       scroll_en0_r, scroll_en1_r;
  logic [7:0] period_r;
  logic [6:0] row_addr0_r, row_addr1_r;

  logic [LW-1:0] text_len_r [2];
  logic [LW-1:0] scroll_pos_r [2];
  logic [1:0]    pending_r;
  logic [1:0]    load_open_r;
  logic [7:0]    phase_r;

  state_t        state_r, state_nxt;
  logic          ln_r, ln_nxt;
  logic          draw1_r;
  logic          scroll_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r;

  logic [7:0] text_mem [2*MAX_TEXT];
  logic [7:0] rd_data_r;

  logic       out_tvalid_r, out_tuser_r, out_tlast_r;
  logic [7:0] out_tdata_r;

  logic          in_fire, out_free;
  logic          in_ln;
  logic [LW-1:0] load_len;
  logic          load_store;
  logic          load_close;
  logic [8:0]    phase_inc;
  logic          tick_fire, draw0, draw1;

  logic [LW-1:0] len_cur, pos_cur, idx0;
  logic          en_cur, scroll_mode_c;
  logic [IW-1:0] inc_base, inc_res;
  logic          inc_scroll;
  logic          last_char;
  logic          is_space;
  logic [7:0]    char_out;
  logic [AW-1:0] wr_addr, rd_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_ln     = in_tuser[1];

  assign load_len   = load_open_r[in_ln] ? text_len_r[in_ln] : '0;
  assign load_store = (in_tdata != 8'd0) && (int'(load_len) < MAX_TEXT);
  assign load_close = (in_tdata == 8'd0) || in_tlast;

  assign phase_inc = {1'b0, phase_r} + 9'd1;
  assign tick_fire = (phase_inc >= {1'b0, period_r});
  assign draw0     = pending_r[0] || (tick_fire && scroll_en0_r);
  assign draw1     = pending_r[1] || (tick_fire && scroll_en1_r);

  assign len_cur       = text_len_r[ln_r];
  assign pos_cur       = scroll_pos_r[ln_r];
  assign en_cur        = ln_r ? scroll_en1_r : scroll_en0_r;
  assign scroll_mode_c = en_cur && (int'(len_cur) > LINE_CHARS);
  assign idx0          = (pos_cur > len_cur) ? '0 : pos_cur;

  // Shared index unit: steps the read position, wrapping at length + 1 when scrolling.
  assign inc_base   = (state_r == S_CMD) ? IW'(idx0) : idx_r;
  assign inc_scroll = (state_r == S_CMD) ? scroll_mode_c : scroll_r;
  assign inc_res    = (inc_scroll && (inc_base == IW'(len_cur))) ? '0 : inc_base + IW'(1);

  assign last_char = (cnt_r == CW'(LINE_CHARS - 1));
  assign is_space  = (idx_r >= IW'(len_cur)) || (rd_data_r == 8'd0);
  assign char_out  = is_space ? SPACE_CHAR : rd_data_r;

  always_comb begin
    state_nxt = state_r;
    ln_nxt    = ln_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser[0] == CMD_TICK) && (draw0 || draw1)) begin
          state_nxt = S_CMD;
          ln_nxt    = !draw0;
        end
      end
      S_CMD: begin
        if (out_free) begin
          state_nxt = S_DATA;
          idx_nxt   = scroll_mode_c ? IW'(idx0) : '0;
        end
      end
      S_DATA: begin
        if (out_free) begin
          idx_nxt = inc_res;
          if (last_char) begin
            if (draw1_r) begin
              state_nxt = S_CMD;
              ln_nxt    = 1'b1;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign wr_addr = in_ln  ? AW'(MAX_TEXT) + AW'(load_len) : AW'(load_len);
  assign rd_addr = ln_nxt ? AW'(MAX_TEXT) + AW'(idx_nxt)  : AW'(idx_nxt);

  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser[0] == CMD_LOAD) && load_store) begin
      text_mem[wr_addr] <= in_tdata;
    end
    rd_data_r <= text_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_en0_r <= 1'b0;
      scroll_en1_r <= 1'b0;
      period_r     <= 8'd32;
      row_addr0_r  <= 7'd0;
      row_addr1_r  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCROLL_EN0: scroll_en0_r <= cfg_data[0];
        REG_SCROLL_EN1: scroll_en1_r <= cfg_data[0];
        REG_PERIOD:     period_r     <= cfg_data;
        REG_ROW_ADDR0:  row_addr0_r  <= cfg_data[6:0];
        REG_ROW_ADDR1:  row_addr1_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      ln_r            <= 1'b0;
      draw1_r         <= 1'b0;
      scroll_r        <= 1'b0;
      idx_r           <= '0;
      cnt_r           <= '0;
      text_len_r[0]   <= '0;
      text_len_r[1]   <= '0;
      scroll_pos_r[0] <= '0;
      scroll_pos_r[1] <= '0;
      pending_r       <= '0;
      load_open_r     <= '0;
      phase_r         <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ln_r    <= ln_nxt;
      idx_r   <= idx_nxt;

      if ((state_r != S_IDLE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser[0] == CMD_LOAD) begin
              if (!load_open_r[in_ln]) begin
                scroll_pos_r[in_ln] <= '0;
              end
              text_len_r[in_ln]  <= load_store ? load_len + LW'(1) : load_len;
              load_open_r[in_ln] <= !load_close;
              if (load_close) begin
                pending_r[in_ln] <= 1'b1;
              end
            end else begin
              phase_r <= tick_fire ? 8'd0 : phase_inc[7:0];
              draw1_r <= draw0 && draw1;
            end
          end
        end
        S_CMD: begin
          if (out_free) begin
            out_tuser_r       <= 1'b1;
            out_tdata_r       <= SET_DDRAM_OP | {1'b0, (ln_r ? row_addr1_r : row_addr0_r)};
            out_tlast_r       <= 1'b0;
            scroll_r          <= scroll_mode_c;
            cnt_r             <= '0;
            pending_r[ln_r]   <= 1'b0;
            if (scroll_mode_c) begin
              scroll_pos_r[ln_r] <= LW'(inc_res);
            end
          end
        end
        S_DATA: begin
          if (out_free) begin
            out_tuser_r  <= 1'b0;
            out_tdata_r  <= char_out;
            out_tlast_r  <= last_char && !draw1_r;
            cnt_r        <= cnt_r + CW'(1);
            if (last_char) begin
              draw1_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !out_tlast)
    else $error("address command marked as last byte of a run");

  a_scroll_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DATA) && scroll_r) |-> (idx_r <= IW'(len_cur)))
    else $error("scroll index beyond text length");

  a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> !pending_r[ln_r])
    else $error("redraw flag still set while line is being drawn");

endmodule
